@@ sv/be3_pkg.sv @@
package be3_pkg;

  // pixel and register field widths
  localparam int PIX_W     = 8;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 12;
  localparam int MASK_W    = 9;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND_VALUE = 3'd4;

  // register reset values
  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 12'd1024;
  localparam logic [MASK_W-1:0]  RST_KERNEL_MASK  = 9'h1ff;
  localparam logic [PIX_W-1:0]   RST_BACKGROUND   = 8'd0;
  localparam logic [PIX_W-1:0]   RST_FOREGROUND   = 8'd255;

  // item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // geometry
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int KERNEL_SIZE       = 3;

  // input row runs past the frame height while draining
  localparam int IN_ROW_W  = 13;
  localparam int OUT_ROW_W = 12;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    pixel_t            bg;
    pixel_t            fg;
  } erode_cfg_t;

  typedef struct packed {
    logic   c_zero;
    logic   elig;
    pixel_t edge_px;
  } win_ctl_t;

endpackage

@@ sv/be3_stream_if.sv @@
interface be3_in_if import be3_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  pixel_t pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface be3_out_if import be3_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

@@ sv/be3_ram.sv @@
module be3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/be3_window.sv @@
module be3_window import be3_pkg::*; (
  input  logic       clk,
  input  logic       advance,
  input  pixel_t     col_up,
  input  pixel_t     col_mid,
  input  pixel_t     col_low,
  input  erode_cfg_t cfg,
  input  win_ctl_t   ctl,
  output pixel_t     value
);

  pixel_t win_r   [KERNEL_SIZE][KERNEL_SIZE];
  pixel_t win_nxt [KERNEL_SIZE][KERNEL_SIZE];
  logic   hit;
  pixel_t center;

  // shift one column left, new column enters on the right
  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
        win_nxt[r][k] = win_r[r][k+1];
      end
    end
    win_nxt[0][KERNEL_SIZE-1] = col_up;
    win_nxt[1][KERNEL_SIZE-1] = col_mid;
    win_nxt[2][KERNEL_SIZE-1] = col_low;
  end

  always_comb begin
    hit = 1'b0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        if (cfg.mask[KERNEL_SIZE*r+k] && (win_nxt[r][k] == cfg.bg)) begin
          hit = 1'b1;
        end
      end
    end
  end

  assign center = win_nxt[1][1];

  always_comb begin
    if (ctl.c_zero) begin
      value = ctl.edge_px;
    end else if (ctl.elig && (center == cfg.fg) && hit) begin
      value = cfg.bg;
    end else begin
      value = center;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win_r <= win_nxt;
    end
  end

endmodule

@@ sv/binary_erosion_3x3.sv @@
// streaming 3x3 binary erosion of an 8-bit raster image. one pixel item is
// taken per clock (cmd = pixel) unless the output stalls; each result is the
// pixel one row plus one pixel behind, eroded when it equals the foreground
// value, is not on the frame border and a masked neighbor equals the
// background value. after the last pixel of the frame, send image_width + 1
// drain items (cmd = drain) to flush the pending pixels; the result carrying
// frame_end = 1 closes the frame. pixels sent before that are dropped, as are
// drain items during a frame. throughput is one item per cycle unless the
// output stalls, set by the single line-store access per item; a result
// passes the window stage and then the output register after its item is
// accepted. the line stores are rams of MAX_WIDTH words with no clearing
// pass after reset; the upper line is kept as two copies so the row-end
// pixel and the current column are read in the same cycle. configuration is
// written through cfg_we / cfg_index / cfg_data between items.
module binary_erosion_3x3 import be3_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  be3_in_if.sink                in_ch,
  be3_out_if.source             out_ch
);

  localparam int CW = $clog2(MAX_WIDTH);  // column / ram address bits
  localparam int EW = CW + 1;             // effective width, up to MAX_WIDTH

  // configuration registers
  logic [IMG_W_W-1:0] cfg_width_r;
  logic [IMG_H_W-1:0] cfg_height_r;
  logic [MASK_W-1:0]  cfg_mask_r;
  pixel_t             cfg_bg_r;
  pixel_t             cfg_fg_r;

  // position counters
  logic [CW-1:0]        in_col_r,  in_col_nxt;
  logic [IN_ROW_W-1:0]  in_row_r,  in_row_nxt;
  logic [CW-1:0]        out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;

  // effective geometry
  logic [EW-1:0]      w_eff, w_m1;
  logic [IMG_H_W-1:0] h_eff, h_m1;

  // front-end decode of the offered item
  logic          receiving, skip, accept, proc, emit, col_wrap, frame_end, elig;
  logic [CW-1:0] c0;
  logic [CW-1:0] edge_addr;
  pixel_t        pix0;

  // window stage
  logic          s1_v_r;
  logic          s1_emit_r, s1_fe_r, s1_czero_r, s1_elig_r;
  logic          s1_fwd_up_r, s1_fwd_edge_r;
  pixel_t        s1_fwd_data_r;
  pixel_t        s1_pix_r;
  logic [CW-1:0] s1_c_r;
  logic          s1_move;

  // ram read data
  pixel_t rd_mid, rd_up, rd_edge;
  pixel_t up_px, edge_px;

  // output register
  logic   out_v_r;
  pixel_t out_pixel_r;
  logic   out_fe_r;
  pixel_t win_value;

  erode_cfg_t ero_cfg;
  win_ctl_t   win_ctl;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_IMAGE_WIDTH;
      cfg_height_r <= RST_IMAGE_HEIGHT;
      cfg_mask_r   <= RST_KERNEL_MASK;
      cfg_bg_r     <= RST_BACKGROUND;
      cfg_fg_r     <= RST_FOREGROUND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:      cfg_width_r  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:     cfg_height_r <= cfg_data[IMG_H_W-1:0];
        REG_KERNEL_MASK:      cfg_mask_r   <= cfg_data[MASK_W-1:0];
        REG_BACKGROUND_VALUE: cfg_bg_r     <= cfg_data[PIX_W-1:0];
        REG_FOREGROUND_VALUE: cfg_fg_r     <= cfg_data[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // width of 0 acts as 1, above MAX_WIDTH as MAX_WIDTH; height of 0 as 1
  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = EW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(cfg_width_r);
    end
    h_eff = (cfg_height_r == '0) ? IMG_H_W'(1) : cfg_height_r;
  end

  assign w_m1      = w_eff - EW'(1);
  assign h_m1      = h_eff - IMG_H_W'(1);
  assign edge_addr = w_m1[CW-1:0];

  // ---------------------------------------------------------------------
  // front end: all control is settled from the counters at acceptance
  // ---------------------------------------------------------------------
  assign s1_move     = s1_v_r && (!s1_emit_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_move;
  assign accept      = in_ch.valid && in_ch.ready;

  assign receiving = in_row_r < IN_ROW_W'(h_eff);
  // pixel after the frame is in, or drain while the frame is still coming
  assign skip = ((in_ch.cmd == CMD_PIXEL) && !receiving) ||
                ((in_ch.cmd == CMD_DRAIN) && receiving);
  assign proc = accept && !skip;
  assign pix0 = (in_ch.cmd == CMD_DRAIN) ? '0 : in_ch.pixel_in;

  // column clamps to the last one if the width shrank
  assign c0 = ({1'b0, in_col_r} >= w_eff) ? w_m1[CW-1:0] : in_col_r;

  assign emit = (in_row_r >= IN_ROW_W'(2)) ||
                ((in_row_r == IN_ROW_W'(1)) && (c0 != '0));
  assign col_wrap = ({1'b0, c0} + EW'(1)) >= w_eff;

  assign frame_end = (out_row_r > h_m1) ||
                     ((out_row_r == h_m1) && ({1'b0, out_col_r} >= w_m1));

  // output position is off the frame border
  assign elig = (h_eff >= IMG_H_W'(3)) && (w_eff >= EW'(3)) &&
                (out_row_r != '0) &&
                ((IN_ROW_W'(out_row_r) + IN_ROW_W'(2)) <= IN_ROW_W'(h_eff)) &&
                (out_col_r != '0) &&
                (({1'b0, out_col_r} + EW'(2)) <= w_eff);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (proc) begin
      if (emit && frame_end) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (col_wrap) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + IN_ROW_W'(1);
        end else begin
          in_col_nxt = c0 + CW'(1);
        end
        if (emit) begin
          if (({1'b0, out_col_r} + EW'(1)) >= w_eff) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + OUT_ROW_W'(1);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // line stores
  // middle line: read and written at the item's column on acceptance
  // upper line: takes the old middle word when the item leaves the window
  // stage; reads that land on that same edge are forwarded
  // ---------------------------------------------------------------------
  be3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (proc),
    .waddr (c0),
    .wdata (pix0),
    .re    (proc),
    .raddr (c0),
    .rdata (rd_mid)
  );

  be3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_c_r),
    .wdata (rd_mid),
    .re    (proc),
    .raddr (c0),
    .rdata (rd_up)
  );

  // copy of the upper line for the row-end pixel
  be3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_edge_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_c_r),
    .wdata (rd_mid),
    .re    (proc),
    .raddr (edge_addr),
    .rdata (rd_edge)
  );

  // ---------------------------------------------------------------------
  // window stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (proc) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1_emit_r     <= emit;
      s1_fe_r       <= frame_end;
      s1_czero_r    <= (c0 == '0);
      s1_elig_r     <= elig;
      s1_pix_r      <= pix0;
      s1_c_r        <= c0;
      // the item now leaving writes its old middle word this same edge
      s1_fwd_up_r   <= s1_v_r && (s1_c_r == c0);
      s1_fwd_edge_r <= s1_v_r && (s1_c_r == edge_addr);
      s1_fwd_data_r <= rd_mid;
    end
  end

  assign up_px   = s1_fwd_up_r   ? s1_fwd_data_r : rd_up;
  assign edge_px = s1_fwd_edge_r ? s1_fwd_data_r : rd_edge;

  assign ero_cfg = '{mask: cfg_mask_r, bg: cfg_bg_r, fg: cfg_fg_r};
  assign win_ctl = '{c_zero: s1_czero_r, elig: s1_elig_r, edge_px: edge_px};

  be3_window u_window (
    .clk     (clk),
    .advance (s1_move),
    .col_up  (up_px),
    .col_mid (rd_mid),
    .col_low (s1_pix_r),
    .cfg     (ero_cfg),
    .ctl     (win_ctl),
    .value   (win_value)
  );

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move && s1_emit_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit_r) begin
      out_pixel_r <= win_value;
      out_fe_r    <= s1_fe_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.pixel_out = out_pixel_r;
  assign out_ch.frame_end = out_fe_r;

`ifndef SYNTH
  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_move && s1_emit_r && out_v_r && !out_ch.ready))
    else $error("result register overwritten while stalled");

  // forwarding relies on the window stage emptying whenever an item enters
  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_v_r) |-> s1_move)
    else $error("item entered while window stage held");

  // the item that ends the frame clears every counter
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit && frame_end) |=>
      (in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0))
    else $error("counters not cleared at frame end");

  // a result appears only from an emitting item leaving the window stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_move && s1_emit_r))
    else $error("result without a source item");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import be3_pkg::*;

  // line store depth of the block under test (default parameter)
  localparam int LINE_DEPTH = DEFAULT_MAX_WIDTH;
  // run limit in ns, several times the slowest legal run
  localparam longint RUN_LIMIT_NS = 64'd2_000_000;

  typedef struct {
    logic   cmd;
    pixel_t pixel;
  } stream_item_t;

  typedef struct {
    pixel_t pixel;
    logic   frame_end;
  } eroded_px_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  be3_in_if  in_ch ();
  be3_out_if out_ch ();

  binary_erosion_3x3 uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // items waiting to be driven, and eroded pixels waiting to come out
  stream_item_t stream_q[$];
  eroded_px_t   eroded_q[$];

  bit failed;
  bit in_took;          // input handshake seen at the last rising edge
  int send_idle_pct;    // chance per cycle that the sender holds back
  int stall_pct;        // chance per cycle that the receiver stalls

  // shadow copy of the configuration registers, updated on each write
  logic [IMG_W_W-1:0] sh_width  = RST_IMAGE_WIDTH;
  logic [IMG_H_W-1:0] sh_height = RST_IMAGE_HEIGHT;
  logic [MASK_W-1:0]  sh_mask   = RST_KERNEL_MASK;
  pixel_t             sh_bg     = RST_BACKGROUND;
  pixel_t             sh_fg     = RST_FOREGROUND;

  // erosion state: two row buffers, the 3x3 window and the raster counters
  pixel_t      two_rows_up [LINE_DEPTH];
  pixel_t      one_row_up  [LINE_DEPTH];
  pixel_t      win [3][3];
  int unsigned in_col, in_row, out_col, out_row;

  // generator view of the configuration (effective sizes)
  int unsigned gen_w, gen_h;
  pixel_t      gen_bg, gen_fg;

  // advance the erosion state by one accepted item, queue the pixel it releases
  function automatic void erode_pixel_step(input logic cmd, input pixel_t px_in);
    int unsigned w, h, c;
    int          r, k;
    pixel_t      px, edge_px, value;
    bit          recv, emit, hit, last_px;
    eroded_px_t  res;
    w = (sh_width == 0) ? 1 : ((sh_width > LINE_DEPTH) ? LINE_DEPTH : sh_width);
    h = (sh_height == 0) ? 1 : sh_height;
    recv = in_row < h;
    // pixels after the frame and drains during the frame are dropped
    if (cmd == CMD_PIXEL && !recv) return;
    if (cmd == CMD_DRAIN && recv) return;
    px = (cmd == CMD_DRAIN) ? '0 : px_in;
    c = (in_col >= w) ? w - 1 : in_col;
    // last pixel of the older row, read before this item overwrites it
    edge_px = two_rows_up[w - 1];
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = two_rows_up[c];
    win[1][2] = one_row_up[c];
    win[2][2] = px;
    two_rows_up[c] = one_row_up[c];
    one_row_up[c] = px;
    emit = (in_row >= 2) || (in_row == 1 && c >= 1);
    if (c + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = c + 1;
    end
    if (!emit) return;
    if (c == 0) begin
      value = edge_px;
    end else begin
      value = win[1][1];
      // only interior foreground pixels can erode
      if (value == sh_fg && h >= 3 && w >= 3 && out_row >= 1 && out_row + 2 <= h &&
          out_col >= 1 && out_col + 2 <= w) begin
        hit = 0;
        for (r = 0; r < 3; r++)
          for (k = 0; k < 3; k++)
            if (sh_mask[3 * r + k] && win[r][k] == sh_bg) hit = 1;
        if (hit) value = sh_bg;
      end
    end
    last_px = (out_row > h - 1) || (out_row == h - 1 && out_col >= w - 1);
    if (last_px) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    res.pixel     = value;
    res.frame_end = last_px;
    eroded_q = {eroded_q, res};
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // checker: results against the oldest expectation, config writes and
  // accepted items into the erosion state, all sampled at the rising edge
  always @(posedge clk) begin : scoreboard
    eroded_px_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (eroded_q.size() == 0) begin
          $error("unexpected item: pixel_out %0d frame_end %0d",
                 out_ch.pixel_out, out_ch.frame_end);
          failed = 1'b1;
        end else begin
          want = eroded_q.pop_front();
          if (out_ch.pixel_out !== want.pixel) begin
            $error("pixel_out mismatch: expected %0d, actual %0d",
                   want.pixel, out_ch.pixel_out);
            failed = 1'b1;
          end
          if (out_ch.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0d, actual %0d",
                   want.frame_end, out_ch.frame_end);
            failed = 1'b1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:      sh_width  = cfg_data[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT:     sh_height = cfg_data[IMG_H_W-1:0];
          REG_KERNEL_MASK:      sh_mask   = cfg_data[MASK_W-1:0];
          REG_BACKGROUND_VALUE: sh_bg     = cfg_data[PIX_W-1:0];
          REG_FOREGROUND_VALUE: sh_fg     = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        in_took = 1'b1;
        erode_pixel_step(in_ch.cmd, in_ch.pixel_in);
      end
    end
  end

  // driver: next item goes out at the falling edge once the slot is free,
  // with random sender gaps; receiver stalls are drawn every cycle
  always @(negedge clk) begin : driver
    stream_item_t nxt;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.cmd      <= CMD_PIXEL;
      in_ch.pixel_in <= '0;
      out_ch.ready   <= 1'b0;
    end else begin
      if (!in_ch.valid || in_took) begin
        if (stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = stream_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.cmd      <= nxt.cmd;
          in_ch.pixel_in <= nxt.pixel;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void push_item(input logic cmd, input pixel_t px);
    stream_item_t it;
    it.cmd   = cmd;
    it.pixel = px;
    stream_q = {stream_q, it};
  endfunction

  // mostly foreground and background so erosion actually happens
  function automatic pixel_t random_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return gen_fg;
    if (r < 85) return gen_bg;
    return pixel_t'($urandom_range(255));
  endfunction

  // one whole frame plus its flush; noise adds drains inside the frame and
  // pixels during the flush, both of which the block drops
  function automatic int unsigned queue_frame(input int noise_pct);
    int unsigned n;
    for (n = 0; n < gen_w * gen_h; n++) begin
      if ($urandom_range(99) < noise_pct) push_item(CMD_DRAIN, pixel_t'($urandom_range(255)));
      push_item(CMD_PIXEL, random_pixel());
    end
    for (n = 0; n <= gen_w; n++) begin
      if (n > 0 && $urandom_range(99) < noise_pct)
        push_item(CMD_PIXEL, pixel_t'($urandom_range(255)));
      push_item(CMD_DRAIN, pixel_t'($urandom_range(255)));
    end
    return gen_w * gen_h + gen_w + 1;
  endfunction

  // idling modes rotate per phase
  function automatic void pick_idling(input int unsigned ph);
    case (ph % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 51; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 51; end
      default: begin send_idle_pct = 24; stall_pct = 24; end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    int unsigned v;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        v = value & 32'h7ff;
        gen_w = (v == 0) ? 1 : ((v > LINE_DEPTH) ? LINE_DEPTH : v);
      end
      REG_IMAGE_HEIGHT: begin
        v = value & 32'hfff;
        gen_h = (v == 0) ? 1 : v;
      end
      REG_BACKGROUND_VALUE: gen_bg = pixel_t'(value);
      REG_FOREGROUND_VALUE: gen_fg = pixel_t'(value);
      default: ;
    endcase
  endtask

  // wait until every item is in and every result is out, then let the
  // pipeline run dry
  task automatic settle();
    while (stream_q.size() != 0 || in_ch.valid || eroded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic frame_phase(input int unsigned w, input int unsigned h,
                             input int unsigned mask, input int unsigned bg,
                             input int unsigned fg, input int unsigned ph);
    pick_idling(ph);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_KERNEL_MASK, mask);
    write_reg(REG_BACKGROUND_VALUE, bg);
    write_reg(REG_FOREGROUND_VALUE, fg);
    void'(queue_frame(0));
    settle();
  endtask

  initial begin : stimulus
    int unsigned rand_items, ph, frames, f, n, r;
    int unsigned new_w, new_h;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    gen_w          = RST_IMAGE_WIDTH;
    gen_h          = RST_IMAGE_HEIGHT;
    gen_bg         = RST_BACKGROUND;
    gen_fg         = RST_FOREGROUND;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // hand-built 4x3 frame: the interior pixel next to the background corner
    // erodes, the other interior pixel stays; a drain with nothing pending,
    // a drain inside the frame and a pixel during the flush are all dropped
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_KERNEL_MASK, 511);
    write_reg(REG_BACKGROUND_VALUE, 0);
    write_reg(REG_FOREGROUND_VALUE, 255);
    push_item(CMD_DRAIN, 8'hff);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd7);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_DRAIN, 8'h00);
    push_item(CMD_PIXEL, 8'd128);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd0);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_DRAIN, 8'h00);
    push_item(CMD_DRAIN, 8'h00);
    push_item(CMD_PIXEL, 8'h5a);
    push_item(CMD_DRAIN, 8'h00);
    push_item(CMD_DRAIN, 8'h00);
    push_item(CMD_DRAIN, 8'h00);
    settle();

    // size extremes: width and height of zero, a tall one-pixel column,
    // frames too narrow or short to erode, background equal to foreground
    ph = 0;
    frame_phase(0, 0, 511, 0, 255, ph++);
    frame_phase(1, 40, 511, 0, 255, ph++);
    frame_phase(2, 5, 511, 0, 255, ph++);
    frame_phase(5, 2, 511, 0, 255, ph++);
    frame_phase(3, 3, 9'h1ff, 200, 200, ph++);

    // configuration changed inside a frame: width and height shrink after
    // three rows and two pixels; surplus pixels land in the flush and are dropped
    pick_idling(ph++);
    write_reg(REG_IMAGE_WIDTH, 6);
    write_reg(REG_IMAGE_HEIGHT, 6);
    write_reg(REG_KERNEL_MASK, $urandom_range(511));
    write_reg(REG_BACKGROUND_VALUE, 0);
    write_reg(REG_FOREGROUND_VALUE, 255);
    for (n = 0; n < 20; n++) push_item(CMD_PIXEL, random_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 5);
    write_reg(REG_KERNEL_MASK, $urandom_range(511));
    for (n = 0; n < 28; n++) push_item(CMD_PIXEL, random_pixel());
    for (n = 0; n < 14; n++) push_item(CMD_DRAIN, 8'h00);
    settle();

    // random frames, mostly small, each phase with fresh settings; the
    // directed part above already sent close to 170 items
    rand_items = 0;
    while (rand_items < 760) begin
      pick_idling(ph++);
      if ($urandom_range(99) < 70) begin
        r = $urandom_range(99);
        new_w = (r < 8) ? $urandom_range(13, 40) : ((r < 11) ? 0 : $urandom_range(1, 12));
        write_reg(REG_IMAGE_WIDTH, new_w);
      end
      if ($urandom_range(99) < 70) begin
        r = $urandom_range(99);
        new_h = (r < 8) ? $urandom_range(13, 40) : ((r < 11) ? 0 : $urandom_range(1, 12));
        write_reg(REG_IMAGE_HEIGHT, new_h);
      end
      if ($urandom_range(99) < 60) begin
        r = $urandom_range(99);
        write_reg(REG_KERNEL_MASK, (r < 20) ? 511 : ((r < 30) ? 0 : $urandom_range(511)));
      end
      if ($urandom_range(99) < 50) begin
        r = $urandom_range(99);
        if (r < 30) begin
          write_reg(REG_BACKGROUND_VALUE, 0);
          write_reg(REG_FOREGROUND_VALUE, 255);
        end else if (r < 45) begin
          write_reg(REG_BACKGROUND_VALUE, 255);
          write_reg(REG_FOREGROUND_VALUE, 0);
        end else if (r < 55) begin
          // background equal to foreground
          n = $urandom_range(255);
          write_reg(REG_BACKGROUND_VALUE, n);
          write_reg(REG_FOREGROUND_VALUE, n);
        end else begin
          write_reg(REG_BACKGROUND_VALUE, $urandom_range(255));
          write_reg(REG_FOREGROUND_VALUE, $urandom_range(255));
        end
      end
      frames = $urandom_range(1, 2);
      for (f = 0; f < frames; f++)
        rand_items += queue_frame(($urandom_range(1) == 1) ? 4 : 0);
      settle();
    end

    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
